// File: rtl/hsm_pkg.sv
// hsm_pkg: shared types and constants of the hashed substring matcher.
// Beat structs for the text and result channels and the register indexes.
// No dependencies.
`default_nettype none

package hsm_pkg;

	localparam int BYTE_BITS   = 8;
	localparam int PAT_W       = 64;  // pattern register, up to eight bytes
	localparam int LEN_W       = 4;   // pattern length register
	localparam int MATCH_POS_W = 16;  // match_position field
	localparam int BUCKET_W    = 5;   // bucket field
	localparam int SUM_W       = 11;  // byte sum of up to eight bytes
	localparam int CFG_IDX_W   = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

	typedef struct packed {
		logic [BYTE_BITS-1:0] text_byte;
		logic                 last_byte;
	} text_beat_t;

	typedef struct packed {
		logic                   found;
		logic [MATCH_POS_W-1:0] match_position;
		logic [BUCKET_W-1:0]    bucket;
		logic                   done_res;
	} result_beat_t;

	// per-beat outcome of the window compare, handed to the bucket pipeline
	typedef struct packed {
		logic                   emit;   // this beat yields a result
		logic                   found;
		logic                   done;
		logic [MATCH_POS_W-1:0] pos;
		logic [SUM_W-1:0]       sum;
	} hit_t;

endpackage

`default_nettype wire

// File: rtl/hsm_window.sv
// hsm_window: text window, byte counter and match flag, plus the byte compare.
// Produces one hit_t per accepted beat. Depends on hsm_pkg.
`default_nettype none

module hsm_window #(
	parameter int MAX_PATTERN   = 8,
	parameter int POSITION_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  hsm_pkg::text_beat_t         beat,
	input  logic [hsm_pkg::PAT_W-1:0]   pattern_bytes,
	input  logic [hsm_pkg::LEN_W-1:0]   pattern_length,
	output hsm_pkg::hit_t               hit
);
	import hsm_pkg::*;

	localparam int WIN_W  = BYTE_BITS * MAX_PATTERN;
	localparam int SEEN_W = POSITION_BITS + 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	logic [WIN_W-1:0]         win_q, win_next, shifted, cur, pat;
	logic [SEEN_W-1:0]        seen_q, seen_next, start;
	logic [POSITION_BITS-1:0] start_sat;
	logic                     any_q, match;
	logic [LEN_W-1:0]         len_eff;
	logic [SUM_W-1:0]         sum;

	// length clamps to 1..MAX_PATTERN
	always_comb begin
		if (pattern_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (pattern_length > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = pattern_length;
		end
	end

	// newest byte enters the top octet
	assign win_next = (win_q >> BYTE_BITS) |
		(WIN_W'(beat.text_byte) << (BYTE_BITS * (MAX_PATTERN - 1)));

	// bring the newest len_eff bytes down to octet 0
	assign shifted = win_next >> {MAX_LEN - len_eff, 3'b000};

	always_comb begin
		cur = '0;
		pat = '0;
		sum = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LEN_W'(i) < len_eff) begin
				cur[i*BYTE_BITS +: BYTE_BITS] = shifted[i*BYTE_BITS +: BYTE_BITS];
				pat[i*BYTE_BITS +: BYTE_BITS] = pattern_bytes[i*BYTE_BITS +: BYTE_BITS];
			end
			sum = sum + SUM_W'(cur[i*BYTE_BITS +: BYTE_BITS]);
		end
	end

	assign seen_next = (&seen_q) ? seen_q : seen_q + SEEN_W'(1);
	assign start     = seen_next - SEEN_W'(len_eff);
	assign start_sat = start[POSITION_BITS] ? '1 : start[POSITION_BITS-1:0];

	// equal bytes imply equal buckets, so the byte compare alone gates a hit
	assign match = (seen_next >= SEEN_W'(len_eff)) && (cur == pat);

	always_comb begin
		hit.emit  = match | (beat.last_byte & ~any_q);
		hit.found = match;
		hit.done  = beat.last_byte;
		hit.pos   = match ? MATCH_POS_W'(start_sat) : '0;
		hit.sum   = sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			seen_q <= '0;
			any_q  <= 1'b0;
		end else if (accept) begin
			if (beat.last_byte) begin
				win_q  <= '0;
				seen_q <= '0;
				any_q  <= 1'b0;
			end else begin
				win_q  <= win_next;
				seen_q <= seen_next;
				any_q  <= any_q | match;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/hsm_bucket_pipe.sv
// hsm_bucket_pipe: two pipeline stages and the result register; reduces the
// window sum modulo the bucket count by reciprocal multiply. Depends on hsm_pkg.
`default_nettype none

module hsm_bucket_pipe #(
	parameter int HASH_BUCKETS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  hsm_pkg::hit_t          hit,
	output logic                   ready,
	input  logic                   result_stall,
	output logic                   result_valid,
	output hsm_pkg::result_beat_t  result_beat
);
	import hsm_pkg::*;

	// floor(x / HB) == (x * RECIP) >> RSHIFT exactly for every x below 2**SUM_W
	localparam int RSHIFT = SUM_W + $clog2(HASH_BUCKETS);
	localparam int MW     = RSHIFT + 1;
	localparam int PROD_W = SUM_W + MW;
	localparam int QW     = PROD_W - RSHIFT;
	localparam int QPW    = QW + 9;
	localparam int BKT_W  = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << RSHIFT) + 64'(HASH_BUCKETS) - 64'd1) / 64'(HASH_BUCKETS);
	localparam logic [MW-1:0] RECIP = RECIP_L[MW-1:0];

	logic              v_s1, v_s2, res_valid_q;
	hit_t              hit_s1, hit_s2;
	logic [PROD_W-1:0] prod_s2;
	result_beat_t      res_q;
	logic              adv_out, adv_s2, adv_s1, load;
	logic [QW-1:0]     quot;
	logic [QPW-1:0]    qprod, rem_full;
	logic [BKT_W-1:0]  rem;

	// bubbles collapse: a stage moves when the one after it is free or moving
	assign adv_out = !res_valid_q || !result_stall;
	assign adv_s2  = !v_s2 || adv_out;
	assign adv_s1  = !v_s1 || adv_s2;
	assign ready   = adv_s1;
	assign load    = take & hit.emit;

	assign quot     = prod_s2[PROD_W-1:RSHIFT];
	assign qprod    = QPW'(quot) * QPW'(HASH_BUCKETS);
	assign rem_full = QPW'(hit_s2.sum) - qprod;
	assign rem      = rem_full[BKT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= load;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				res_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && load) begin
			hit_s1 <= hit;
		end
		if (adv_s2 && v_s1) begin
			hit_s2  <= hit_s1;
			prod_s2 <= PROD_W'(hit_s1.sum) * PROD_W'(RECIP);
		end
		if (adv_out && v_s2) begin
			res_q.found          <= hit_s2.found;
			res_q.match_position <= hit_s2.pos;
			res_q.bucket         <= hit_s2.found ? BUCKET_W'(rem) : '0;
			res_q.done_res       <= hit_s2.done;
		end
	end

	assign result_valid = res_valid_q;
	assign result_beat  = res_q;

endmodule

`default_nettype wire

// File: rtl/hashed_substring_matcher.sv
// hashed_substring_matcher: top level; config registers and channel wiring.
// Depends on hsm_pkg, hsm_window and hsm_bucket_pipe.
//
// Usage:
//   Text enters one byte per beat on text_valid/text_stall/text_beat; a beat
//   moves at a clock edge with valid high and stall low. last_byte closes a
//   text, and the window, byte count and match flag clear for the next one.
//   Each beat yields at most one result beat on result_valid/result_stall/
//   result_beat: a match (found=1, start offset and bucket), or on the last
//   byte of a text with no match at all, a not-found beat (found=0, done=1).
//   Beats without a result leave nothing in the pipeline.
//   Throughput is one text beat per cycle while text_stall is low. After its
//   text beat is accepted, a result passes stage one (window compare), stage
//   two (reciprocal multiply) and the result register (remainder).
//   When the receiver stalls, the result register holds; text beats keep
//   being taken until both pipeline stages behind it are full, after which
//   text_stall rises.
//   Config writes (cfg_valid/cfg_ready, index 0 pattern bytes, index 1
//   pattern length) are taken every cycle and belong between texts.
//   Reset (arst_n low) empties the pipeline, clears the window state and
//   sets the pattern to zero with length one.
`default_nettype none

module hashed_substring_matcher #(
	parameter int MAX_PATTERN   = 8,
	parameter int HASH_BUCKETS  = 20,
	parameter int POSITION_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              text_valid,
	output logic                              text_stall,
	input  hsm_pkg::text_beat_t               text_beat,
	output logic                              result_valid,
	input  logic                              result_stall,
	output hsm_pkg::result_beat_t             result_beat,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hsm_pkg::PAT_W-1:0]         cfg_data
);
	import hsm_pkg::*;

	logic [PAT_W-1:0] pattern_bytes_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic             pipe_ready, accept;
	hit_t             hit;

	// config port never back-pressures
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q  <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES: begin
					pattern_bytes_q <= cfg_data;
				end
				REG_PATTERN_LENGTH: begin
					pattern_length_q <= cfg_data[LEN_W-1:0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	// a text beat is taken whenever the first pipeline stage can move
	assign text_stall = !pipe_ready;
	assign accept     = text_valid && pipe_ready;

	hsm_window #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_BITS (POSITION_BITS)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.beat           (text_beat),
		.pattern_bytes  (pattern_bytes_q),
		.pattern_length (pattern_length_q),
		.hit            (hit)
	);

	hsm_bucket_pipe #(
		.HASH_BUCKETS (HASH_BUCKETS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (accept),
		.hit          (hit),
		.ready        (pipe_ready),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_beat  (result_beat)
	);

`ifndef SYNTH
	// with the result register empty nothing can back up into the text side
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !text_stall)
		else $error("text stalled with empty result register");

	// a not-found beat closes a text and carries no position or bucket
	a_not_found_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_beat.found) |->
		(result_beat.done_res && result_beat.match_position == '0 &&
		 result_beat.bucket == '0))
		else $error("malformed not-found result");

	// remainder stays below the bucket count when the field can hold it
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		((HASH_BUCKETS > 32) || (32'(result_beat.bucket) < HASH_BUCKETS)))
		else $error("bucket out of range");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for hashed_substring_matcher.
// Holds its own scoreboard model of the matcher and checks every result beat.
// Depends on hsm_pkg and the hashed_substring_matcher RTL.
`default_nettype none

module tb;
	import hsm_pkg::*;

	localparam int MAX_PAT      = 8;
	localparam int BUCKETS      = 20;
	localparam int POS_BITS     = 16;
	localparam int RANDOM_ITEMS = 1500;
	localparam int LONG_BYTES   = 200;     // one longer text with several planted hits
	localparam int QUIET_LIMIT  = 2000;    // cycles with no beat anywhere before giving up
	localparam int DRAIN_CYCLES = 8;       // pipeline is three registers deep; pad generously
	localparam int MAX_ERR_LINES = 200;

	// receiver stall patterns
	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   text_valid   = 1'b0;
	logic                   text_stall;
	text_beat_t             text_beat    = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_beat_t           result_beat;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [PAT_W-1:0]       cfg_data     = '0;

	always #5 clk = ~clk;

	hashed_substring_matcher #(
		.MAX_PATTERN  (MAX_PAT),
		.HASH_BUCKETS (BUCKETS),
		.POSITION_BITS(POS_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_beat   (text_beat),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_beat (result_beat),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// ------------------------------------------------------------------
	// Scoreboard model: config copy, window state, pending and expected beats
	// ------------------------------------------------------------------
	logic [PAT_W-1:0]     pat_reg  = '0;
	logic [LEN_W-1:0]     len_reg  = 4'd1;
	logic [63:0]          win_bytes = '0;    // newest byte in the top octet
	logic [POS_BITS:0]    seen_cnt = '0;     // saturating byte count of the open text
	logic                 any_hit  = 1'b0;   // open text already produced a match

	text_beat_t   text_pending[$];
	result_beat_t match_expected[$];

	int err_count = 0;
	int res_idx   = 0;

	// lengths outside 1..8 clamp to the nearest legal value
	function automatic int unsigned eff_len();
		if (len_reg == 0)
			return 1;
		if (len_reg > MAX_PAT)
			return MAX_PAT;
		return {28'd0, len_reg};
	endfunction

	// Advance the window by one accepted text beat and queue the result it owes.
	task automatic window_step(input text_beat_t beat);
		int unsigned  n, wsum, psum, st;
		logic [63:0]  cur, pmask, pat;
		result_beat_t r;
		n = eff_len();
		win_bytes = {beat.text_byte, win_bytes[63:8]};
		if (seen_cnt != '1)
			seen_cnt = seen_cnt + 1'b1;
		// newest n bytes, oldest of them in the low octet
		cur   = win_bytes >> (8 * (MAX_PAT - n));
		pmask = (n == MAX_PAT) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
		pat   = pat_reg & pmask;
		wsum  = 0;
		psum  = 0;
		for (int j = 0; j < n; j++) begin
			wsum += 32'(cur[8*j +: 8]);
			psum += 32'(pat[8*j +: 8]);
		end
		r = '0;
		if (32'(seen_cnt) >= n && (wsum % BUCKETS) == (psum % BUCKETS) && cur == pat) begin
			st = 32'(seen_cnt) - n;
			r.found          = 1'b1;
			r.match_position = (st > 32'hFFFF) ? '1 : MATCH_POS_W'(st);
			r.bucket         = BUCKET_W'(wsum % BUCKETS);
			r.done_res       = beat.last_byte;
			any_hit = 1'b1;
			match_expected.push_back(r);
		end else if (beat.last_byte && !any_hit) begin
			// end of text with nothing found
			r.done_res = 1'b1;
			match_expected.push_back(r);
		end
		if (beat.last_byte) begin
			win_bytes = '0;
			seen_cnt  = '0;
			any_hit   = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_ERR_LINES)
			$display("ERROR result beat %0d: %s", res_idx, what);
	endtask

	// ------------------------------------------------------------------
	// Text driver: bursts of random length with random gaps between them.
	// hold_sender freezes new beats (the beat on the wire still completes).
	// ------------------------------------------------------------------
	logic        hold_sender = 1'b0;
	int unsigned burst_left  = 0;
	int unsigned gap_left    = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (text_valid && !text_stall)
				window_step(text_beat);
			// a stalled beat stays put; otherwise decide on the next one
			if (!text_valid || !text_stall) begin
				if (gap_left != 0) begin
					gap_left   <= gap_left - 1;
					text_valid <= 1'b0;
				end else if (!hold_sender && text_pending.size() != 0) begin
					text_beat  <= text_pending.pop_front();
					text_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						// a quarter of bursts run straight into the next one
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: stall pattern switches at random intervals.
	// stretch_req starts one long hold-off, counted here.
	// ------------------------------------------------------------------
	logic        stretch_req = 1'b0;
	int unsigned hold_left   = 0;
	int unsigned mode_left   = 0;
	rx_mode_t    rx_mode     = RX_FREE;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left    <= 0;
			mode_left    <= 0;
			rx_mode      <= RX_FREE;
		end else begin
			if (stretch_req)
				hold_left <= 90;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;

			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(32, 200);
			end else begin
				mode_left <= mode_left - 1;
			end

			if (stretch_req || hold_left != 0) begin
				result_stall <= 1'b1;
			end else begin
				case (rx_mode)
					RX_FREE:     result_stall <= 1'b0;
					RX_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
					default:     result_stall <= (mode_left[1:0] == 2'd0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare each accepted beat with the oldest expectation
	// ------------------------------------------------------------------
	result_beat_t want;

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (match_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected beat found=%0b pos=%0d bucket=%0d done=%0b",
					result_beat.found, result_beat.match_position,
					result_beat.bucket, result_beat.done_res));
			end else begin
				want = match_expected.pop_front();
				if (result_beat.found !== want.found)
					report_mismatch($sformatf("found %0b, want %0b",
						result_beat.found, want.found));
				if (result_beat.match_position !== want.match_position)
					report_mismatch($sformatf("match_position %0d, want %0d",
						result_beat.match_position, want.match_position));
				if (result_beat.bucket !== want.bucket)
					report_mismatch($sformatf("bucket %0d, want %0d",
						result_beat.bucket, want.bucket));
				if (result_beat.done_res !== want.done_res)
					report_mismatch($sformatf("done_res %0b, want %0b",
						result_beat.done_res, want.done_res));
			end
			res_idx++;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any beat on any channel resets the quiet count
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (result_valid && !result_stall) ||
			    (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: %0d results still expected", match_expected.size());
				$display("hashed_substring_matcher: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_PATTERN_BYTES)
			pat_reg = data;
		else if (idx == REG_PATTERN_LENGTH)
			len_reg = data[LEN_W-1:0];
	endtask

	// length word with junk in the bits above the register
	function automatic logic [PAT_W-1:0] len_word(input logic [LEN_W-1:0] l);
		return {32'($urandom), 28'($urandom), l};
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic l);
		text_beat_t t;
		t.text_byte = b;
		t.last_byte = l;
		text_pending.push_back(t);
	endtask

	// Idle = nothing queued, nothing on the wire, nothing owed; sampled mid-cycle
	// so the driver's edge updates are settled. Then let the pipeline flush.
	task automatic wait_idle();
		do @(negedge clk);
		while (text_pending.size() != 0 || text_valid || match_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One text, mostly built from whole or cut-short copies of the pattern so
	// that matches and near misses are common; the rest is pattern bytes out
	// of order and plain noise.
	task automatic make_text(input int unsigned nbytes, input bit close);
		int unsigned n, i, k, r;
		n = eff_len();
		i = 0;
		while (i < nbytes) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				k = (r < 3) ? n : $urandom_range(1, n);
				for (int j = 0; j < k && i < nbytes; j++) begin
					push_byte(pat_reg[8*j +: 8], close && i == nbytes - 1);
					i++;
				end
			end else begin
				push_byte((r < 8) ? pat_reg[8*$urandom_range(0, n - 1) +: 8] : 8'($urandom),
					close && i == nbytes - 1);
				i++;
			end
		end
	endtask

	// start offsets of the planted pattern in the long text
	function automatic bit long_start(input int unsigned p);
		return (p % 64) == 5 || p == LONG_BYTES - 2;
	endfunction

	int unsigned random_items = 0;
	int unsigned phase_items, target, nbytes, phase;
	bit          leave_open;
	int unsigned r;
	logic [3:0]  l;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// --- reset config: pattern 0x00, length 1; zero byte is a real byte
		push_byte(8'h00, 1'b0);  // match at 0
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);  // match on the closing byte, no not-found after
		push_byte(8'hFF, 1'b1);  // one-byte text, nothing found
		wait_idle();

		// --- length 0 behaves as 1
		write_reg(REG_PATTERN_LENGTH, len_word(4'd0));
		write_reg(REG_PATTERN_BYTES, {32'($urandom), 24'($urandom), 8'hFF});
		push_byte(8'hFF, 1'b1);
		wait_idle();

		// --- length 15 clamps to 8; short text first, then an exact hit
		write_reg(REG_PATTERN_LENGTH, len_word(4'd15));
		write_reg(REG_PATTERN_BYTES, 64'h0807060504030201);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h03, 1'b1);  // shorter than the pattern
		for (int j = 1; j <= 8; j++)
			push_byte(8'(j), j == 8);
		wait_idle();

		// --- all-ones pattern at full length, overlapping hits
		write_reg(REG_PATTERN_LENGTH, len_word(4'd8));
		write_reg(REG_PATTERN_BYTES, '1);
		for (int j = 0; j < 9; j++)
			push_byte(8'hFF, j == 8);
		wait_idle();

		// --- one longer text: pattern planted every 64 bytes, last hit on the
		// closing byte
		write_reg(REG_PATTERN_LENGTH, len_word(4'd2));
		write_reg(REG_PATTERN_BYTES, {32'($urandom), 16'($urandom), 16'hA55A});
		for (int unsigned p = 0; p < LONG_BYTES; p++) begin
			if (long_start(p))
				push_byte(8'h5A, p == LONG_BYTES - 1);
			else if (p != 0 && long_start(p - 1))
				push_byte(8'hA5, p == LONG_BYTES - 1);
			else
				push_byte(8'h00, p == LONG_BYTES - 1);
		end
		wait_idle();

		// --- random phases, a fresh config each; some end mid-text so the
		// next config (often a new length) applies to a half-seen window
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (phase == 1)
				l = 4'd1;  // dense results for the long hold-off
			else if (r == 0)
				l = 4'd0;
			else if (r == 1)
				l = 4'($urandom_range(9, 15));
			else
				l = 4'($urandom_range(1, 8));
			r = $urandom_range(0, 9);
			write_reg(REG_PATTERN_BYTES, (r == 0) ? '0 : (r == 1) ? '1 :
				{32'($urandom), 32'($urandom)});
			write_reg(REG_PATTERN_LENGTH, len_word(l));

			target      = $urandom_range(120, 240);
			leave_open  = ($urandom_range(0, 2) == 0);
			phase_items = 0;
			while (phase_items < target) begin
				nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
					: $urandom_range(1, 24);
				make_text(nbytes, !(leave_open && phase_items + nbytes >= target));
				phase_items += nbytes;
			end
			random_items += phase_items;

			if (phase == 1) begin
				// receiver goes quiet while the sender keeps pushing: the
				// pipeline fills and text_stall must rise
				@(posedge clk);
				stretch_req <= 1'b1;
				@(posedge clk);
				stretch_req <= 1'b0;
			end else if (phase == 3) begin
				// sender pauses mid-phase until the block has drained
				while (text_pending.size() > phase_items / 2)
					@(posedge clk);
				hold_sender <= 1'b1;
				do @(posedge clk); while (text_valid || match_expected.size() != 0);
				hold_sender <= 1'b0;
			end
			wait_idle();
			phase++;
		end

		if (err_count == 0)
			$display("hashed_substring_matcher: match");
		else
			$display("hashed_substring_matcher: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
